[src/isl_pkg.sv]
// isl_pkg: shared widths, operation codes, datapath commands and status
// used by the interval table controller, datapath and top level
package isl_pkg;

  localparam int TableDepth = 64;
  localparam int TimeBits   = 32;
  localparam int TaskBits   = 16;
  localparam int AddrW      = $clog2(TableDepth);
  localparam int CntW       = $clog2(TableDepth + 1);

  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_CHECK  = 2'd2;

  typedef struct packed {
    logic [TimeBits-1:0] start_t;
    logic [TimeBits-1:0] end_t;
    logic [TaskBits-1:0] task_id;
  } entry_t;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LATCH,
    CMD_APPEND,
    CMD_S_INIT,
    CMD_S_OUTER,
    CMD_S_KEY,
    CMD_S_INNER,
    CMD_S_CMP,
    CMD_L_INIT,
    CMD_L_LOOP,
    CMD_L_CMP,
    CMD_L_FIN,
    CMD_C_INIT,
    CMD_C_OUTER,
    CMD_C_KEY,
    CMD_C_INNER,
    CMD_C_CMP,
    CMD_EMIT
  } cmd_e;

  typedef struct packed {
    logic [1:0] op;
    logic       sorted;
    logic       i_done;
    logic       j_zero;
    logic       start_gt;
    logic       lo_lt_hi;
    logic       ci_done;
    logic       cj_done;
  } stat_t;

endpackage

[src/isl_dp.sv]
// isl_dp: interval table memory, sort/search/check index registers and results
// depends on isl_pkg
module isl_dp import isl_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_e                cmd_i,
  output stat_t               stat_o,
  input  logic [1:0]          operation_i,
  input  logic [TimeBits-1:0] start_time_i,
  input  logic [TimeBits-1:0] end_time_i,
  input  logic [TaskBits-1:0] task_ident_i,
  input  logic [TimeBits-1:0] query_time_i,
  output logic                found_o,
  output logic [TaskBits-1:0] found_task_o,
  output logic                consistent_o,
  output logic                status_o
);

  entry_t mem [TableDepth];
  entry_t rd_q, key_q, in_q;
  logic [1:0] op_q;
  logic [TimeBits-1:0] query_q;
  logic [CntW-1:0] cnt_q, i_q, j_q, lo_q, hi_q, mid_q, mid_c;
  logic sorted_q, ok_q, found_q, status_q;
  logic [TaskBits-1:0] task_q;
  logic we, re;
  logic [AddrW-1:0] waddr, raddr;
  entry_t wdata;
  logic full;

  assign full  = (cnt_q == CntW'(TableDepth));
  assign mid_c = lo_q + ((hi_q - lo_q) >> 1);

  assign stat_o.op       = op_q;
  assign stat_o.sorted   = sorted_q;
  assign stat_o.i_done   = (i_q >= cnt_q);
  assign stat_o.j_zero   = (j_q == '0);
  assign stat_o.start_gt = (rd_q.start_t > key_q.start_t);
  assign stat_o.lo_lt_hi = (lo_q < hi_q);
  assign stat_o.ci_done  = (({1'b0, i_q} + (CntW+1)'(1)) >= {1'b0, cnt_q});
  assign stat_o.cj_done  = (j_q >= cnt_q);

  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = j_q[AddrW-1:0];
    raddr = i_q[AddrW-1:0];
    wdata = key_q;
    unique case (cmd_i)
      CMD_APPEND: begin
        we    = !full;
        waddr = cnt_q[AddrW-1:0];
        wdata = in_q;
      end
      CMD_S_OUTER: re = !stat_o.i_done;
      CMD_S_INNER: begin
        if (stat_o.j_zero) begin
          we = 1'b1;
        end else begin
          re    = 1'b1;
          raddr = AddrW'(j_q - CntW'(1));
        end
      end
      CMD_S_CMP: begin
        we    = 1'b1;
        wdata = stat_o.start_gt ? rd_q : key_q;
      end
      CMD_L_LOOP: begin
        if (stat_o.lo_lt_hi) begin
          re    = 1'b1;
          raddr = mid_c[AddrW-1:0];
        end else if (lo_q != '0) begin
          re    = 1'b1;
          raddr = AddrW'(lo_q - CntW'(1));
        end
      end
      CMD_C_OUTER: re = !stat_o.ci_done;
      CMD_C_INNER: begin
        re    = !stat_o.cj_done;
        raddr = j_q[AddrW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rd_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      sorted_q <= 1'b1;
    end else begin
      if (cmd_i == CMD_APPEND && !full) begin
        cnt_q    <= cnt_q + CntW'(1);
        sorted_q <= 1'b0;
      end
      if (cmd_i == CMD_S_OUTER && stat_o.i_done) sorted_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i)
      CMD_LATCH: begin
        op_q     <= operation_i;
        in_q     <= '{start_t: start_time_i, end_t: end_time_i, task_id: task_ident_i};
        query_q  <= query_time_i;
        found_q  <= 1'b0;
        task_q   <= '0;
        status_q <= 1'b0;
        ok_q     <= 1'b1;
      end
      CMD_APPEND: status_q <= full;
      CMD_S_INIT: i_q <= CntW'(1);
      CMD_S_KEY: begin
        key_q <= rd_q;
        j_q   <= i_q;
      end
      CMD_S_INNER: if (stat_o.j_zero) i_q <= i_q + CntW'(1);
      CMD_S_CMP: begin
        if (stat_o.start_gt) j_q <= j_q - CntW'(1);
        else i_q <= i_q + CntW'(1);
      end
      CMD_L_INIT: begin
        lo_q <= '0;
        hi_q <= cnt_q;
      end
      CMD_L_LOOP: mid_q <= mid_c;
      CMD_L_CMP: begin
        if (rd_q.start_t <= query_q) lo_q <= mid_q + CntW'(1);
        else hi_q <= mid_q;
      end
      CMD_L_FIN: begin
        if (lo_q != '0 && rd_q.end_t > query_q) begin
          found_q <= 1'b1;
          task_q  <= rd_q.task_id;
        end
      end
      CMD_C_INIT: i_q <= '0;
      CMD_C_KEY: begin
        key_q <= rd_q;
        j_q   <= i_q + CntW'(1);
      end
      CMD_C_INNER: if (stat_o.cj_done) i_q <= i_q + CntW'(1);
      CMD_C_CMP: begin
        if (rd_q.task_id == key_q.task_id) ok_q <= 1'b0;
        if (j_q == i_q + CntW'(1) && key_q.end_t > rd_q.start_t) ok_q <= 1'b0;
        j_q <= j_q + CntW'(1);
      end
      CMD_EMIT: begin
        found_o      <= found_q;
        found_task_o <= task_q;
        consistent_o <= (op_q == OP_CHECK) && ok_q;
        status_o     <= status_q;
      end
      default: ;
    endcase
  end

endmodule

[src/isl_ctrl.sv]
// isl_ctrl: sequencing state machine for append, sort, lookup and check
// depends on isl_pkg; drives isl_dp through cmd_e commands
module isl_ctrl import isl_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  stat_t stat_i,
  output cmd_e  cmd_o
);

  localparam logic [4:0] ST_IDLE    = 5'd0;
  localparam logic [4:0] ST_DISP    = 5'd1;
  localparam logic [4:0] ST_APP     = 5'd2;
  localparam logic [4:0] ST_S_INIT  = 5'd3;
  localparam logic [4:0] ST_S_OUTER = 5'd4;
  localparam logic [4:0] ST_S_KEY   = 5'd5;
  localparam logic [4:0] ST_S_INNER = 5'd6;
  localparam logic [4:0] ST_S_CMP   = 5'd7;
  localparam logic [4:0] ST_L_INIT  = 5'd8;
  localparam logic [4:0] ST_L_LOOP  = 5'd9;
  localparam logic [4:0] ST_L_CMP   = 5'd10;
  localparam logic [4:0] ST_L_FIN   = 5'd11;
  localparam logic [4:0] ST_C_INIT  = 5'd12;
  localparam logic [4:0] ST_C_OUTER = 5'd13;
  localparam logic [4:0] ST_C_KEY   = 5'd14;
  localparam logic [4:0] ST_C_INNER = 5'd15;
  localparam logic [4:0] ST_C_CMP   = 5'd16;
  localparam logic [4:0] ST_DONE    = 5'd17;

  logic [4:0] state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic emit;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign emit        = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    cmd_o   = CMD_NONE;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) begin
        cmd_o   = CMD_LATCH;
        state_d = ST_DISP;
      end
      ST_DISP: begin
        if (stat_i.op == OP_APPEND) state_d = ST_APP;
        else if (stat_i.op == OP_LOOKUP || stat_i.op == OP_CHECK)
          state_d = !stat_i.sorted ? ST_S_INIT
                  : (stat_i.op == OP_LOOKUP) ? ST_L_INIT : ST_C_INIT;
        else state_d = ST_DONE;
      end
      ST_APP: begin
        cmd_o   = CMD_APPEND;
        state_d = ST_DONE;
      end
      ST_S_INIT: begin
        cmd_o   = CMD_S_INIT;
        state_d = ST_S_OUTER;
      end
      ST_S_OUTER: begin
        cmd_o = CMD_S_OUTER;
        if (!stat_i.i_done) state_d = ST_S_KEY;
        else state_d = (stat_i.op == OP_LOOKUP) ? ST_L_INIT : ST_C_INIT;
      end
      ST_S_KEY: begin
        cmd_o   = CMD_S_KEY;
        state_d = ST_S_INNER;
      end
      ST_S_INNER: begin
        cmd_o   = CMD_S_INNER;
        state_d = stat_i.j_zero ? ST_S_OUTER : ST_S_CMP;
      end
      ST_S_CMP: begin
        cmd_o   = CMD_S_CMP;
        state_d = stat_i.start_gt ? ST_S_INNER : ST_S_OUTER;
      end
      ST_L_INIT: begin
        cmd_o   = CMD_L_INIT;
        state_d = ST_L_LOOP;
      end
      ST_L_LOOP: begin
        cmd_o   = CMD_L_LOOP;
        state_d = stat_i.lo_lt_hi ? ST_L_CMP : ST_L_FIN;
      end
      ST_L_CMP: begin
        cmd_o   = CMD_L_CMP;
        state_d = ST_L_LOOP;
      end
      ST_L_FIN: begin
        cmd_o   = CMD_L_FIN;
        state_d = ST_DONE;
      end
      ST_C_INIT: begin
        cmd_o   = CMD_C_INIT;
        state_d = ST_C_OUTER;
      end
      ST_C_OUTER: begin
        cmd_o   = CMD_C_OUTER;
        state_d = stat_i.ci_done ? ST_DONE : ST_C_KEY;
      end
      ST_C_KEY: begin
        cmd_o   = CMD_C_KEY;
        state_d = ST_C_INNER;
      end
      ST_C_INNER: begin
        cmd_o   = CMD_C_INNER;
        state_d = stat_i.cj_done ? ST_C_OUTER : ST_C_CMP;
      end
      ST_C_CMP: begin
        cmd_o   = CMD_C_CMP;
        state_d = ST_C_INNER;
      end
      ST_DONE: if (emit) begin
        cmd_o   = CMD_EMIT;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (emit) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[src/interval_schedule_lookup_core.sv]
// interval_schedule_lookup_core: sorted interval table with append, lookup, check
// a stable insertion sort runs before the first lookup or check that follows appends;
// every operation reads or writes the table memory one word at a time
// reset clears the entry count and marks the table sorted; no clearing pass
module interval_schedule_lookup_core import isl_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          operation_i,
  input  logic [TimeBits-1:0] start_time_i,
  input  logic [TimeBits-1:0] end_time_i,
  input  logic [TaskBits-1:0] task_ident_i,
  input  logic [TimeBits-1:0] query_time_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                found_o,
  output logic [TaskBits-1:0] found_task_o,
  output logic                consistent_o,
  output logic                status_o
);

  cmd_e  cmd;
  stat_t stat;

  isl_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .stat_i(stat), .cmd_o(cmd)
  );

  isl_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat),
    .operation_i, .start_time_i, .end_time_i, .task_ident_i, .query_time_i,
    .found_o, .found_task_o, .consistent_o, .status_o
  );

endmodule

[src/isl_checker.sv]
// isl_checker: port-level assertions for interval_schedule_lookup_core
// depends on isl_pkg; attached by bind
module isl_checker import isl_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic                found_o,
  input logic [TaskBits-1:0] found_task_o,
  input logic                consistent_o,
  input logic                status_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(found_task_o) && $stable(found_o))
    else $error("result word changed while stalled");

  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $countones({found_o, consistent_o, status_o}) <= 1)
    else $error("result carries fields of two operations");

  a_task_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> found_task_o == '0)
    else $error("task id without a hit");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("accepted a word while busy");

endmodule

bind interval_schedule_lookup_core isl_checker u_isl_checker (.*);
